@@ rtl/gfpa_pkg.sv @@
`default_nettype none
package gfpa_pkg;

    localparam int SYM_W    = 3;
    localparam int IN_TERMS = 10;
    localparam int MAX_TERMS = 10;
    localparam int LIM      = (MAX_TERMS < IN_TERMS) ? MAX_TERMS : IN_TERMS;
    localparam int WORK     = 22;
    localparam int POLY_W   = SYM_W * IN_TERMS;

    typedef logic [SYM_W-1:0] sym_t;
    typedef sym_t [WORK-1:0] work_t;

    typedef enum logic [3:0] {
        OP_MUL    = 4'd0,
        OP_DIV    = 4'd1,
        OP_INV    = 4'd2,
        OP_SCALE  = 4'd3,
        OP_PMUL   = 4'd4,
        OP_MPMUL  = 4'd5,
        OP_MOD    = 4'd6,
        OP_EVAL   = 4'd7,
        OP_DERIV  = 4'd8,
        OP_DEGREE = 4'd9
    } op_t;

    function automatic sym_t gf_mul(input sym_t a, input sym_t b);
        logic [4:0] r;
        r = 5'd0;
        for (int i = 0; i < 3; i++)
            if (b[i]) r = r ^ (5'({2'b00, a}) << i);
        if (r[4]) r = r ^ 5'b10110;
        if (r[3]) r = r ^ 5'b01011;
        return r[2:0];
    endfunction

    function automatic sym_t gf_inv(input sym_t a);
        sym_t r;
        unique case (a)
            3'd0: r = 3'd0;
            3'd1: r = 3'd1;
            3'd2: r = 3'd5;
            3'd3: r = 3'd6;
            3'd4: r = 3'd7;
            3'd5: r = 3'd2;
            3'd6: r = 3'd3;
            default: r = 3'd4;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

@@ rtl/gf8_packed_polynomial_alu.sv @@
// Channel | Direction | Fields
// in      | in        | opcode poly_a poly_b size_a size_b scalar_a scalar_b
// out     | out       | poly_result elem_result degree error
// One beat per cycle while not stalled, through four stages plus output.
// Stage 1 unpacks, stages 2-4 run four remainder steps and up to four Horner terms each (two in stage 4).
// The output stage forms the products, quotients and inverses, packs the result and flags errors.
// A stall holds every stage; rst_n clears the valid bits only.
`default_nettype none
module gf8_packed_polynomial_alu (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [3:0]  opcode,
    input  wire logic [29:0] poly_a,
    input  wire logic [29:0] poly_b,
    input  wire logic [3:0]  size_a,
    input  wire logic [3:0]  size_b,
    input  wire logic [2:0]  scalar_a,
    input  wire logic [2:0]  scalar_b,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [29:0]      poly_result,
    output logic [2:0]       elem_result,
    output logic signed [4:0] degree,
    output logic             error
);
    import gfpa_pkg::*;

    typedef struct packed {
        logic [3:0] op;
        work_t      p;
        work_t      b;
        logic [4:0] top;
        logic [4:0] low;
        logic [3:0] na;
        sym_t       sa;
        sym_t       sb;
        logic [4:0] deg;
        sym_t       ev;
    } st_t;

    logic adv;
    assign adv = !out_stall || !out_valid;
    assign in_stall = !adv;

    st_t s_reg [4];
    logic [3:0] v_reg;
    st_t s_next [4];

    function automatic logic [3:0] sat(input logic [3:0] s);
        if (s == 4'd0) return 4'd1;
        if (s > 4'd10) return 4'd10;
        return s;
    endfunction

    always_comb
    begin
        logic [3:0] na, nb;
        st_t s;
        s = '0;
        na = sat(size_a);
        nb = sat(size_b);
        s.op = opcode; s.sa = scalar_a; s.sb = scalar_b;
        s.na = na;
        s.deg = 5'h1F;
        for (int k = 0; k < IN_TERMS; k++)
            if (poly_a[3*k +: 3] != 3'd0) s.deg = 5'(k);
        if (opcode == OP_MOD)
        begin
            for (int k = 0; k < IN_TERMS; k++)
            begin
                if (4'(k) < na) s.p[5'(k) + 5'(nb) - 5'd1] = poly_a[3*k +: 3];
                if (4'(k) < nb) s.b[k] = poly_b[3*k +: 3];
            end
        end
        else
        begin
            for (int k = 0; k < IN_TERMS; k++)
            begin
                s.p[k] = poly_a[3*k +: 3];
                s.b[k] = poly_b[3*k +: 3];
            end
            if (opcode == OP_MPMUL) s.b[0] = 3'd1;
        end
        s.top = 5'(na) + 5'(nb) - 5'd2;
        s.low = 5'(nb) - 5'd1;
        s_next[0] = s;
    end

    genvar g;
    generate
        for (g = 1; g < 4; g++)
        begin : g_stage
            work_t pp [5];
            st_t   s;
            assign pp[0] = s_reg[g-1].p;
            for (genvar m = 0; m < 4; m++)
            begin : g_step
                gfpa_mod_step u_step (
                    .p_in (pp[m]),
                    .b_in (s_reg[g-1].b),
                    .idx  (s_reg[g-1].top - 5'(4*(g-1) + m)),
                    .low  (s_reg[g-1].low),
                    .en   (s_reg[g-1].op == OP_MOD &&
                           5'(4*(g-1) + m) <= s_reg[g-1].top),
                    .p_out(pp[m+1])
                );
            end
            always_comb
            begin
                sym_t e;
                s = s_reg[g-1];
                e = s.ev;
                if (s.op == OP_MOD) s.p = pp[4];
                for (int k = 0; k < 4; k++)
                    if (5'(k + 4*(g-1)) < 5'(IN_TERMS) &&
                        4'(IN_TERMS - 1 - k - 4*(g-1)) < s.na)
                        e = gf_mul(e, s.sb) ^ s.p[IN_TERMS - 1 - k - 4*(g-1)];
                s.ev = e;
                s_next[g] = s;
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (adv)
            v_reg <= {v_reg[2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            for (int i = 0; i < 4; i++)
                s_reg[i] <= s_next[i];
    end

    logic [29:0] poly_next;
    sym_t elem_next;
    logic err_next;

    always_comb
    begin
        st_t s;
        work_t r;
        logic [4:0] n;
        s = s_reg[3];
        r = '0;
        n = 5'd0;
        elem_next = 3'd0;
        err_next = 1'b0;
        unique case (s.op)
            OP_MUL: elem_next = gf_mul(s.sa, s.sb);
            OP_DIV:
            begin
                err_next = (s.sb == 3'd0);
                elem_next = gf_mul(s.sa, gf_inv(s.sb));
            end
            OP_INV:
            begin
                err_next = (s.sb == 3'd0);
                elem_next = gf_inv(s.sb);
            end
            OP_SCALE:
            begin
                n = 5'(IN_TERMS);
                for (int i = 0; i < IN_TERMS; i++) r[i] = gf_mul(s.p[i], s.sb);
            end
            OP_PMUL, OP_MPMUL:
            begin
                n = 5'(2*IN_TERMS - 1);
                for (int i = 0; i < IN_TERMS; i++)
                    for (int j = 0; j < IN_TERMS; j++)
                        r[i+j] = r[i+j] ^ gf_mul(s.p[i], s.b[j]);
            end
            OP_MOD:
            begin
                n = s.top + 5'd1;
                r = s.p;
            end
            OP_EVAL: elem_next = s.ev;
            OP_DERIV:
            begin
                n = 5'(IN_TERMS);
                for (int i = 1; i < IN_TERMS; i += 2) r[i-1] = s.p[i];
            end
            default: ;
        endcase
        poly_next = '0;
        for (int i = 0; i < WORK; i++)
            if (5'(i) < n)
            begin
                if (i < LIM) poly_next[3*i +: 3] = r[i];
                else if (r[i] != 3'd0) err_next = 1'b1;
            end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid <= 1'b0;
        else if (adv)
            out_valid <= v_reg[3];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            poly_result <= poly_next;
            elem_result <= elem_next;
            degree      <= s_reg[3].deg;
            error       <= err_next;
        end
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(poly_result))
        else $error("output changed under stall");
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output stall");
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && elem_result != 3'd0 |-> poly_result == 30'd0)
        else $error("both results nonzero");
endmodule
`default_nettype wire

@@ rtl/gfpa_mod_step.sv @@
`default_nettype none
module gfpa_mod_step (
    input  wire gfpa_pkg::work_t p_in,
    input  wire gfpa_pkg::work_t b_in,
    input  wire logic [4:0]      idx,
    input  wire logic [4:0]      low,
    input  wire logic            en,
    output gfpa_pkg::work_t      p_out
);
    import gfpa_pkg::*;

    sym_t c;

    always_comb
    begin
        c = p_in[idx];
        p_out = p_in;
        if (en && idx >= low)
        begin
            for (int j = 0; j < IN_TERMS; j++)
                if (5'(j) < 5'(WORK) - (idx - low))
                    p_out[5'(j) + idx - low] = p_in[5'(j) + idx - low] ^ gf_mul(b_in[j], c);
        end
    end
endmodule
`default_nettype wire

@@ bench/tb_gf8_packed_polynomial_alu.sv @@
`timescale 1ns / 100ps
`default_nettype none
module tb_gf8_packed_polynomial_alu;
    import gfpa_pkg::*;

    typedef struct packed {
        logic [3:0]  opcode;
        logic [29:0] poly_a;
        logic [29:0] poly_b;
        logic [3:0]  size_a;
        logic [3:0]  size_b;
        logic [2:0]  scalar_a;
        logic [2:0]  scalar_b;
    } alu_req_t;

    typedef struct packed {
        logic [29:0]       poly_result;
        logic [2:0]        elem_result;
        logic signed [4:0] degree;
        logic              error;
    } alu_rsp_t;

    typedef struct {
        alu_req_t req;
        logic     known;
        alu_rsp_t rsp;
    } vec_row_t;

    localparam int RANDOM_BEATS = 800;
    localparam logic [29:0] ALL_ONES  = 30'h3FFF_FFFF;
    localparam logic [29:0] ALT_SEVEN = 30'o7070707070;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [3:0]  opcode;
    logic [29:0] poly_a;
    logic [29:0] poly_b;
    logic [3:0]  size_a;
    logic [3:0]  size_b;
    logic [2:0]  scalar_a;
    logic [2:0]  scalar_b;
    logic        out_valid;
    logic        out_stall;
    logic [29:0] poly_result;
    logic [2:0]  elem_result;
    logic signed [4:0] degree;
    logic        error;

    alu_rsp_t pending_rsp[$];
    int       fail_count;
    bit       feed_done;

    gf8_packed_polynomial_alu DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .opcode      (opcode),
        .poly_a      (poly_a),
        .poly_b      (poly_b),
        .size_a      (size_a),
        .size_b      (size_b),
        .scalar_a    (scalar_a),
        .scalar_b    (scalar_b),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .poly_result (poly_result),
        .elem_result (elem_result),
        .degree      (degree),
        .error       (error)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic logic [2:0] fmul(logic [2:0] a, logic [2:0] b);
        logic [4:0] acc;
        acc = '0;
        for (int i = 0; i < 3; i++)
            if (b[i])
                acc ^= {2'b00, a} << i;
        for (int i = 4; i >= 3; i--)
            if (acc[i])
                acc ^= 5'b01011 << (i - 3);
        return acc[2:0];
    endfunction

    function automatic logic [2:0] finv(logic [2:0] a);
        for (int c = 1; c < 8; c++)
            if (fmul(a, 3'(c)) == 3'd1)
                return 3'(c);
        return 3'd0;
    endfunction

    function automatic int clamp_terms(logic [3:0] s);
        if (s < 1)
            return 1;
        if (s > 10)
            return 10;
        return s;
    endfunction

    function automatic void fold_terms(input logic [2:0] t[22], input int n,
                                       output logic [29:0] packed_out,
                                       inout logic err);
        packed_out = '0;
        for (int i = 0; i < n && i < 22; i++)
            if (i < LIM)
                packed_out[3*i +: 3] = t[i];
            else if (t[i] != 0)
                err = 1'b1;
    endfunction

    function automatic alu_rsp_t compute_alu(alu_req_t q);
        alu_rsp_t r;
        logic [2:0] ta[22];
        logic [2:0] tb[22];
        logic [2:0] tr[22];
        logic [2:0] c;
        int na, nb, top, low;
        r = '0;
        r.degree = -5'sd1;
        na = clamp_terms(q.size_a);
        nb = clamp_terms(q.size_b);
        for (int i = 0; i < 22; i++)
        begin
            ta[i] = (i < 10) ? q.poly_a[3*i +: 3] : 3'd0;
            tb[i] = (i < 10) ? q.poly_b[3*i +: 3] : 3'd0;
            tr[i] = 3'd0;
        end
        for (int k = 9; k >= 0; k--)
            if (ta[k] != 0 && r.degree == -5'sd1)
                r.degree = 5'(k);
        case (q.opcode)
            OP_MUL: r.elem_result = fmul(q.scalar_a, q.scalar_b);
            OP_DIV:
                if (q.scalar_b == 0)
                    r.error = 1'b1;
                else
                    r.elem_result = fmul(q.scalar_a, finv(q.scalar_b));
            OP_INV:
                if (q.scalar_b == 0)
                    r.error = 1'b1;
                else
                    r.elem_result = finv(q.scalar_b);
            OP_SCALE:
            begin
                for (int i = 0; i < 10; i++)
                    tr[i] = fmul(ta[i], q.scalar_b);
                fold_terms(tr, 10, r.poly_result, r.error);
            end
            OP_PMUL, OP_MPMUL:
            begin
                if (q.opcode == OP_MPMUL)
                    tb[0] = 3'd1;
                for (int i = 0; i < 10; i++)
                    for (int j = 0; j < 10; j++)
                        tr[i+j] ^= fmul(ta[i], tb[j]);
                fold_terms(tr, 19, r.poly_result, r.error);
            end
            OP_MOD:
            begin
                top = na + nb - 2;
                low = nb - 1;
                for (int k = 0; k < na; k++)
                    tr[k + nb - 1] = ta[k];
                for (int i = top; i >= low; i--)
                begin
                    c = tr[i];
                    for (int j = 0; j < nb; j++)
                        tr[i - low + j] ^= fmul(tb[j], c);
                end
                fold_terms(tr, top + 1, r.poly_result, r.error);
            end
            OP_EVAL:
                for (int k = na - 1; k >= 0; k--)
                    r.elem_result = fmul(r.elem_result, q.scalar_b) ^ ta[k];
            OP_DERIV:
            begin
                for (int i = 1; i < 10; i += 2)
                    tr[i-1] = ta[i];
                fold_terms(tr, 10, r.poly_result, r.error);
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic vec_row_t row(logic [3:0] op, logic [29:0] a, logic [29:0] b,
                                     logic [3:0] na, logic [3:0] nb,
                                     logic [2:0] sa, logic [2:0] sb,
                                     logic known = 1'b0,
                                     alu_rsp_t rsp = '0);
        vec_row_t v;
        v.req = '{op, a, b, na, nb, sa, sb};
        v.known = known;
        v.rsp = rsp;
        return v;
    endfunction

    function automatic alu_req_t random_req();
        alu_req_t q;
        int terms;
        q.opcode   = 4'($urandom_range(0, 15) < 14 ? $urandom_range(0, 9)
                                                    : $urandom_range(10, 15));
        q.poly_a   = 30'($urandom);
        q.poly_b   = 30'($urandom);
        q.size_a   = 4'($urandom_range(0, 15));
        q.size_b   = 4'($urandom_range(0, 15));
        q.scalar_a = 3'($urandom_range(0, 7));
        q.scalar_b = 3'($urandom_range(0, 7));
        if ((q.opcode == OP_PMUL || q.opcode == OP_MPMUL) && $urandom_range(0, 2) != 0)
        begin
            terms = $urandom_range(1, 5);
            q.poly_a &= ALL_ONES >> (30 - 3*terms);
            q.poly_b &= ALL_ONES >> (3*terms);
        end
        if (q.opcode == OP_MOD && $urandom_range(0, 2) != 0)
        begin
            q.size_b = 4'($urandom_range(2, 10));
            q.size_a = 4'($urandom_range(1, 11 - q.size_b));
            q.poly_b[3*(q.size_b-1) +: 3] = 3'd1;
        end
        return q;
    endfunction

    task automatic send_beat(alu_req_t q);
        opcode   <= q.opcode;
        poly_a   <= q.poly_a;
        poly_b   <= q.poly_b;
        size_a   <= q.size_a;
        size_b   <= q.size_b;
        scalar_a <= q.scalar_a;
        scalar_b <= q.scalar_b;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic idle_gap();
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    always @(posedge clk)
        if (rst_n && in_valid && !in_stall)
            pending_rsp.push_back(compute_alu('{opcode, poly_a, poly_b, size_a, size_b,
                                                scalar_a, scalar_b}));

    always @(posedge clk)
    begin
        alu_rsp_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_rsp.size() == 0)
            begin
                $error("result beat with nothing expected");
                fail_count++;
            end
            else
            begin
                e = pending_rsp.pop_front();
                if (poly_result !== e.poly_result)
                begin
                    $error("poly_result expected %h actual %h", e.poly_result, poly_result);
                    fail_count++;
                end
                if (elem_result !== e.elem_result)
                begin
                    $error("elem_result expected %0d actual %0d", e.elem_result, elem_result);
                    fail_count++;
                end
                if (degree !== e.degree)
                begin
                    $error("degree expected %0d actual %0d", e.degree, degree);
                    fail_count++;
                end
                if (error !== e.error)
                begin
                    $error("error expected %0d actual %0d", e.error, error);
                    fail_count++;
                end
            end
        end
    end

    // receiver: alternate free-running stretches and random stalls
    always @(negedge clk)
    begin
        if (!rst_n || feed_done && pending_rsp.size() == 0)
            out_stall <= 1'b0;
        else if ($urandom_range(0, 99) < 70)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(0, 2) != 0);
    end

    initial
    begin
        vec_row_t directed[$];
        alu_req_t q;
        int burst;
        int drain;
        fail_count = 0;
        feed_done  = 1'b0;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        opcode     = '0;
        poly_a     = '0;
        poly_b     = '0;
        size_a     = 4'd1;
        size_b     = 4'd1;
        scalar_a   = '0;
        scalar_b   = '0;

        directed.push_back(row(OP_MUL, '0, '0, 1, 1, 0, 0, 1'b1, '{'0, 3'd0, -5'sd1, 1'b0}));
        directed.push_back(row(OP_MUL, ALL_ONES, '0, 10, 10, 7, 7));
        directed.push_back(row(OP_DIV, '0, '0, 1, 1, 5, 0, 1'b1, '{'0, 3'd0, -5'sd1, 1'b1}));
        directed.push_back(row(OP_DIV, '0, '0, 1, 1, 0, 3, 1'b1, '{'0, 3'd0, -5'sd1, 1'b0}));
        directed.push_back(row(OP_DIV, ALL_ONES, '0, 1, 1, 6, 7));
        directed.push_back(row(OP_INV, '0, '0, 1, 1, 0, 0, 1'b1, '{'0, 3'd0, -5'sd1, 1'b1}));
        directed.push_back(row(OP_INV, '0, '0, 1, 1, 0, 1, 1'b1, '{'0, 3'd1, -5'sd1, 1'b0}));
        directed.push_back(row(OP_SCALE, ALL_ONES, '0, 1, 1, 0, 5));
        directed.push_back(row(OP_SCALE, ALL_ONES, '0, 1, 1, 0, 1, 1'b1,
                               '{ALL_ONES, 3'd0, 5'sd9, 1'b0}));
        directed.push_back(row(OP_PMUL, 30'o00000_77777, 30'o00000_77777, 1, 1, 0, 0));
        directed.push_back(row(OP_PMUL, ALL_ONES, ALL_ONES, 1, 1, 0, 0));
        directed.push_back(row(OP_MPMUL, 30'o0000012345, 30'o0000000066, 1, 1, 0, 0));
        directed.push_back(row(OP_MPMUL, ALT_SEVEN, ALL_ONES, 1, 1, 0, 0));
        directed.push_back(row(OP_MOD, 30'o0000000321, 30'o0000001013, 3, 4, 0, 0));
        directed.push_back(row(OP_MOD, ALL_ONES, 30'o0000000053, 10, 2, 0, 0));
        directed.push_back(row(OP_MOD, ALL_ONES, ALL_ONES, 0, 0, 0, 0));
        directed.push_back(row(OP_MOD, ALL_ONES, ALL_ONES, 15, 15, 0, 0));
        directed.push_back(row(OP_EVAL, 30'o7654321, '0, 7, 1, 0, 0, 1'b1,
                               '{'0, 3'd1, 5'sd6, 1'b0}));
        directed.push_back(row(OP_EVAL, ALL_ONES, '0, 10, 1, 0, 7));
        directed.push_back(row(OP_EVAL, ALL_ONES, '0, 0, 1, 0, 3));
        directed.push_back(row(OP_DERIV, ALL_ONES, '0, 1, 1, 0, 0));
        directed.push_back(row(OP_DEGREE, 30'o1000000000, '0, 1, 1, 0, 0, 1'b1,
                               '{'0, 3'd0, 5'sd9, 1'b0}));
        directed.push_back(row(OP_DEGREE, 30'o0000000001, '0, 1, 1, 0, 0, 1'b1,
                               '{'0, 3'd0, 5'sd0, 1'b0}));
        directed.push_back(row(4'd15, ALL_ONES, ALL_ONES, 10, 10, 7, 7, 1'b1,
                               '{'0, 3'd0, 5'sd9, 1'b0}));

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed[i])
        begin
            if (directed[i].known && compute_alu(directed[i].req) !== directed[i].rsp)
            begin
                $error("directed row %0d: table entry disagrees with prediction", i);
                fail_count++;
            end
            send_beat(directed[i].req);
            idle_gap();
        end

        for (int n = 0; n < RANDOM_BEATS; n += burst)
        begin
            burst = $urandom_range(1, 24);
            for (int k = 0; k < burst; k++)
            begin
                q = random_req();
                send_beat(q);
            end
            if ($urandom_range(0, 3) != 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge clk);
            end
        end
        in_valid <= 1'b0;
        feed_done = 1'b1;

        drain = 0;
        while (pending_rsp.size() != 0 && drain < 2000)
        begin
            @(negedge clk);
            drain++;
        end
        repeat (10) @(negedge clk);
        if (fail_count == 0 && pending_rsp.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end
endmodule
`default_nettype wire

@@ sim.f @@
rtl/gfpa_pkg.sv
rtl/gfpa_mod_step.sv
rtl/gf8_packed_polynomial_alu.sv
bench/tb_gf8_packed_polynomial_alu.sv
